FILE: src/row_vector_times_matrix_4x4_macros.svh
// Assertion macros for the checker
`ifndef ROW_VECTOR_TIMES_MATRIX_4X4_MACROS_SVH
`define ROW_VECTOR_TIMES_MATRIX_4X4_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define RVM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define RVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

FILE: src/rvm_pkg.sv
package rvm_pkg;

    // Fixed field and register widths
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_LANES = 4;
    localparam int NUM_COLS  = 4;
    localparam int SLOT_W    = 32;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_XY = 3'd0,
        REG_ROW0_ZW = 3'd1,
        REG_ROW1_XY = 3'd2,
        REG_ROW1_ZW = 3'd3,
        REG_ROW2_XY = 3'd4,
        REG_ROW2_ZW = 3'd5,
        REG_ROW3_XY = 3'd6,
        REG_ROW3_ZW = 3'd7
    } cfg_reg_idx_t;

    // Reset gives the identity matrix
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
        logic signed [DATA_W-1:0] vec_w;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
    } out_item_t;

    // Stage loads handed from the pipeline control to the merge stage
    typedef struct packed {
        logic load_sum;
        logic load_out;
    } stage_ctrl_t;

endpackage

FILE: src/rvm_stream_if.sv
interface rvm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/row_vector_times_matrix_4x4.sv
// Row vector times 4x4 matrix, signed fixed point (WORD_WIDTH bits, FRAC_BITS fraction).
// Each input item [x y z w] gives one result item x*row0 + y*row1 + z*row2 + w*row3;
// the sixteen products are exact, each column sum is exact, then rounded to nearest
// (ties towards plus infinity) and saturated to the signed word range. Four lanes,
// one per vector component, multiply in parallel and a merge stage sums and rounds,
// so one item is taken every cycle while the output is not stalled. Three register
// stages (products, column sums, rounded result) lie between an accepted item and
// its result on the output. Each stage moves on when the one after it has room, so
// while a finished result waits on the output the block still accepts items until
// all three stages are full. The matrix sits in eight 64-bit registers (x/z in the
// low half, y/w in the high half of each) that reset to the identity; write them
// only while no item is in flight.
module row_vector_times_matrix_4x4 #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rvm_pkg::CFG_W-1:0]       cfg_data,
    rvm_stream_if.sink                      in_ch,
    rvm_stream_if.source                    out_ch
);
    import rvm_pkg::*;

    localparam int PROD_W = 2 * WORD_WIDTH;

    logic [CFG_W-1:0]             cfg_reg [NUM_REGS];
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s2_valid_reg, s2_valid_next;
    logic                         s3_valid_reg, s3_valid_next;
    logic                         en1, en2, en3;
    logic                         lane_load;
    stage_ctrl_t                  ctrl;
    in_item_t                     in_item;
    logic signed [WORD_WIDTH-1:0] vec_elem [NUM_LANES];
    logic signed [WORD_WIDTH-1:0] mat      [NUM_LANES][NUM_COLS];
    logic signed [PROD_W-1:0]     prod     [NUM_LANES][NUM_COLS];
    out_item_t                    result;

    // Matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Stage enables: a stage moves when empty or when the next one moves
    assign en3       = !s3_valid_reg || out_ch.ready;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign lane_load = en1 && in_ch.valid;
    assign ctrl.load_sum = en2 && s1_valid_reg;
    assign ctrl.load_out = en3 && s2_valid_reg;

    always_comb
    begin
        s1_valid_next = en1 ? in_ch.valid  : s1_valid_reg;
        s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = en3 ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Vector components, low word bits only
    assign in_item     = in_ch.data;
    assign vec_elem[0] = in_item.vec_x[WORD_WIDTH-1:0];
    assign vec_elem[1] = in_item.vec_y[WORD_WIDTH-1:0];
    assign vec_elem[2] = in_item.vec_z[WORD_WIDTH-1:0];
    assign vec_elem[3] = in_item.vec_w[WORD_WIDTH-1:0];

    // Lanes: one per matrix row
    for (genvar r = 0; r < NUM_LANES; r++)
    begin : g_lane
        for (genvar c = 0; c < NUM_COLS; c++)
        begin : g_elem
            assign mat[r][c] = cfg_reg[r*2 + (c >> 1)][(c & 1)*SLOT_W +: WORD_WIDTH];
        end

        rvm_lane #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_lane (
            .clk  (clk),
            .load (lane_load),
            .elem (vec_elem[r]),
            .row  (mat[r]),
            .prod (prod[r])
        );
    end

    rvm_merge #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_merge (
        .clk    (clk),
        .ctrl   (ctrl),
        .prod   (prod),
        .result (result)
    );

    assign in_ch.ready  = en1;
    assign out_ch.valid = s3_valid_reg;
    assign out_ch.data  = result;
endmodule

FILE: src/rvm_lane.sv
module rvm_lane #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [WORD_WIDTH-1:0]  elem,
    input  logic signed [WORD_WIDTH-1:0]  row  [rvm_pkg::NUM_COLS],
    output logic signed [2*WORD_WIDTH-1:0] prod [rvm_pkg::NUM_COLS]
);
    import rvm_pkg::*;

    localparam int PROD_W = 2 * WORD_WIDTH;

    logic signed [PROD_W-1:0] prod_reg  [NUM_COLS];
    logic signed [PROD_W-1:0] prod_next [NUM_COLS];

    // One exact product per matrix column
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            prod_next[c] = PROD_W'(elem) * PROD_W'(row[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;
endmodule

FILE: src/rvm_merge.sv
module rvm_merge #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           clk,
    input  rvm_pkg::stage_ctrl_t           ctrl,
    input  logic signed [2*WORD_WIDTH-1:0] prod [rvm_pkg::NUM_LANES][rvm_pkg::NUM_COLS],
    output rvm_pkg::out_item_t             result
);
    import rvm_pkg::*;

    localparam int PROD_W = 2 * WORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [WORD_WIDTH-1:0] MAX_W = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] MIN_W = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    logic signed [SUM_W-1:0]      sum_reg  [NUM_COLS];
    logic signed [SUM_W-1:0]      sum_next [NUM_COLS];
    logic signed [SUM_W-1:0]      rnd      [NUM_COLS];
    logic [SUM_W-WORD_WIDTH:0]    top_bits [NUM_COLS];
    logic signed [WORD_WIDTH-1:0] sat      [NUM_COLS];
    logic signed [DATA_W-1:0]     col_out  [NUM_COLS];
    out_item_t                    out_reg;
    out_item_t                    out_next;

    // Exact column sums over the four lanes
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            sum_next[c] = SUM_W'(prod[0][c]) + SUM_W'(prod[1][c])
                        + SUM_W'(prod[2][c]) + SUM_W'(prod[3][c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    // Round to nearest (ties up), then saturate to the word range
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            rnd[c]      = (sum_reg[c] + HALF) >>> FRAC_BITS;
            top_bits[c] = rnd[c][SUM_W-1:WORD_WIDTH-1];
            if ((&top_bits[c]) || !(|top_bits[c]))
            begin
                sat[c] = rnd[c][WORD_WIDTH-1:0];
            end
            else if (rnd[c][SUM_W-1])
            begin
                sat[c] = MIN_W;
            end
            else
            begin
                sat[c] = MAX_W;
            end
            col_out[c] = DATA_W'(sat[c]);
        end
        out_next.out_x = col_out[0];
        out_next.out_y = col_out[1];
        out_next.out_z = col_out[2];
        out_next.out_w = col_out[3];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;
endmodule

FILE: src/rvm_checker.sv
`include "row_vector_times_matrix_4x4_macros.svh"

module rvm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input rvm_pkg::out_item_t out_data
);
    import rvm_pkg::*;

    // A result not taken stays on the output unchanged
    `RVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

    // Input is only held off when the output is full and stalled
    `RVM_ASSERT_SAME(a_ready_only_on_stall, !in_ready, out_valid && !out_ready, "input stalled without output stall")

    // An accepted item has a result on the output once it has passed the pipeline
    `RVM_ASSERT_SAME(a_latency, in_valid && in_ready, ##3 out_valid, "no result three cycles after item")
endmodule

bind row_vector_times_matrix_4x4 rvm_checker u_rvm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
